[rtl/rbop_pkg.sv]
// Shared types, constants and helpers for the raster beam and object position core
package rbop_pkg;

    localparam int unsigned SCREEN_WIDTH = 160;
    localparam int unsigned NUM_OBJ      = 5;

    localparam logic [14:0] FRAME_TICKS     = 15'(208 * 262 / 2);
    localparam logic [7:0]  LINE_TICKS      = 8'd228;
    localparam logic [8:0]  LAST_LINE       = 9'd262;
    localparam logic [8:0]  OVERSCAN_LINE   = 9'd232;
    localparam logic [8:0]  DRAW_FIRST_LINE = 9'd40;
    localparam logic [8:0]  VBLANK_LINE     = 9'd3;
    localparam logic [7:0]  HBLANK_END      = 8'd68;
    localparam logic [7:0]  PLAYER_RES_POS  = 8'd3;
    localparam logic [7:0]  OTHER_RES_POS   = 8'd2;

    // reciprocal for the modulo by screen width, exact for 10-bit operands
    localparam int unsigned MOD_SHIFT = 18;
    localparam int unsigned MOD_RECIP = (2 ** MOD_SHIFT + SCREEN_WIDTH - 1) / SCREEN_WIDTH;

    typedef enum logic [3:0] {
        MD_TICK  = 4'd0,
        MD_WSYNC = 4'd1,
        MD_RESP0 = 4'd2,
        MD_RESP1 = 4'd3,
        MD_RESM0 = 4'd4,
        MD_RESM1 = 4'd5,
        MD_RESBL = 4'd6,
        MD_HMOVE = 4'd7,
        MD_HMCLR = 4'd8,
        MD_SETMV = 4'd9
    } t_mode;

    localparam logic [2:0] RC_VSYNC    = 3'd0;
    localparam logic [2:0] RC_VBLANK   = 3'd1;
    localparam logic [2:0] RC_HBLANK   = 3'd2;
    localparam logic [2:0] RC_DRAW     = 3'd3;
    localparam logic [2:0] RC_OVERSCAN = 3'd4;

    typedef logic [NUM_OBJ-1:0][7:0]        t_pos_arr;
    typedef logic signed [NUM_OBJ-1:0][3:0] t_mot_arr;

    typedef struct packed {
        logic [3:0] mode;
        logic       vsync_on;
    } t_beam_cmd;

    typedef struct packed {
        logic [3:0] mode;
        logic [2:0] object_sel;
        logic [3:0] motion_value;
        logic [7:0] column;
    } t_obj_cmd;

    typedef struct packed {
        logic [7:0] beam_column;
        logic [8:0] beam_line;
        logic [2:0] region;
        logic       frame_done;
        logic       draw_line;
    } t_beam_res;

    typedef struct packed {
        t_beam_res beam;
        t_pos_arr  pos;
    } t_result;

    function automatic logic [7:0] mod_width(input logic [9:0] v);
        logic [27:0] prod;
        logic [9:0]  q;
        logic [9:0]  r;
        prod = 28'(v) * 28'(MOD_RECIP);
        q    = prod[MOD_SHIFT+9:MOD_SHIFT];
        r    = v - 10'(q * 10'(SCREEN_WIDTH));
        return r[7:0];
    endfunction

endpackage

[rtl/rbop_in_if.sv]
// Input channel: one colour-clock beat with strobe code, object select, motion value and vsync bit
interface rbop_in_if;
    logic              valid;
    logic              ready;
    logic [3:0]        mode;
    logic [2:0]        object_sel;
    logic signed [3:0] motion_value;
    logic              vsync_on;

    modport source (output valid, mode, object_sel, motion_value, vsync_on, input ready);
    modport sink   (input valid, mode, object_sel, motion_value, vsync_on, output ready);
endinterface

[rtl/rbop_out_if.sv]
// Output channel: beam, region and object positions for one beat
interface rbop_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] beam_column;
    logic [8:0] beam_line;
    logic [2:0] region;
    logic       frame_done;
    logic       draw_line;
    logic [7:0] player0_pos;
    logic [7:0] player1_pos;
    logic [7:0] missile0_pos;
    logic [7:0] missile1_pos;
    logic [7:0] ball_pos;

    modport source (output valid, beam_column, beam_line, region, frame_done, draw_line,
                    player0_pos, player1_pos, missile0_pos, missile1_pos, ball_pos,
                    input ready);
    modport sink   (input valid, beam_column, beam_line, region, frame_done, draw_line,
                    player0_pos, player1_pos, missile0_pos, missile1_pos, ball_pos,
                    output ready);
endinterface

[rtl/rbop_beam.sv]
// Beam column/line counters, raster region state machine and frame tick counter
module rbop_beam
    import rbop_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_acc,
    input  t_beam_cmd i_cmd,
    output logic [7:0] o_col_pre,
    output t_beam_res o_res
);

    typedef enum logic [4:0] {
        RG_VSYNC    = 5'b00001,
        RG_VBLANK   = 5'b00010,
        RG_HBLANK   = 5'b00100,
        RG_DRAW     = 5'b01000,
        RG_OVERSCAN = 5'b10000
    } t_region;

    function automatic t_region region_for_line(input logic [8:0] line);
        priority if (line >= OVERSCAN_LINE)   return RG_OVERSCAN;
        else if (line >= DRAW_FIRST_LINE)     return RG_HBLANK;
        else if (line >= VBLANK_LINE)         return RG_VBLANK;
        else                                  return RG_VSYNC;
    endfunction

    function automatic logic [2:0] region_code(input t_region rg);
        unique case (rg)
            RG_VSYNC:  return RC_VSYNC;
            RG_VBLANK: return RC_VBLANK;
            RG_HBLANK: return RC_HBLANK;
            RG_DRAW:   return RC_DRAW;
            default:   return RC_OVERSCAN;
        endcase
    endfunction

    logic [7:0]  r_col,  n_col;
    logic [8:0]  r_line, n_line;
    t_region     r_region, n_region;
    logic [14:0] r_tick, n_tick;
    logic        fdone;
    logic        draw;

    always_comb begin
        n_tick = r_tick + 15'd1;
        fdone  = 1'b0;
        if (n_tick >= FRAME_TICKS) begin
            n_tick = '0;
            fdone  = 1'b1;
        end

        n_col    = r_col;
        n_line   = r_line;
        n_region = r_region;
        draw     = 1'b0;
        if (i_cmd.vsync_on && r_region != RG_VSYNC) begin
            n_col    = '0;
            n_line   = '0;
            n_region = RG_VSYNC;
        end
        o_col_pre = n_col;

        if (i_cmd.mode == MD_WSYNC) begin
            draw   = (n_line >= DRAW_FIRST_LINE) && (n_line < OVERSCAN_LINE);
            n_line = n_line + 9'd1;
            n_col  = '0;
            if (n_line >= LAST_LINE) begin
                n_line   = '0;
                n_region = RG_VSYNC;
            end else begin
                n_region = region_for_line(n_line);
            end
        end

        n_col = n_col + 8'd1;

        unique case (n_region)
            RG_VSYNC: begin
                if (n_col >= LINE_TICKS) begin
                    n_col  = '0;
                    n_line = n_line + 9'd1;
                    if (n_line >= VBLANK_LINE) n_region = RG_VBLANK;
                end
            end
            RG_VBLANK: begin
                if (n_col >= LINE_TICKS) begin
                    n_col  = '0;
                    n_line = n_line + 9'd1;
                    if (n_line >= DRAW_FIRST_LINE) n_region = RG_HBLANK;
                end
            end
            RG_HBLANK: begin
                if (n_col >= HBLANK_END) n_region = RG_DRAW;
            end
            RG_DRAW: begin
                if (n_col >= LINE_TICKS) begin
                    n_col  = '0;
                    n_line = n_line + 9'd1;
                    if (n_line >= OVERSCAN_LINE) begin
                        n_region = RG_OVERSCAN;
                    end else begin
                        n_region = RG_HBLANK;
                    end
                end
                // no drawing on the beat that drops into overscan
                if (n_region != RG_OVERSCAN) draw = 1'b1;
            end
            default: begin
                if (n_col >= LINE_TICKS) begin
                    n_col  = '0;
                    n_line = n_line + 9'd1;
                    if (n_line >= LAST_LINE) begin
                        n_line   = '0;
                        n_region = RG_VSYNC;
                        fdone    = 1'b1;
                    end
                end
            end
        endcase

        o_res.beam_column = n_col;
        o_res.beam_line   = n_line;
        o_res.region      = region_code(n_region);
        o_res.frame_done  = fdone;
        o_res.draw_line   = draw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_line   <= '0;
            r_region <= RG_VSYNC;
            r_tick   <= '0;
        end else if (i_acc) begin
            r_col    <= n_col;
            r_line   <= n_line;
            r_region <= n_region;
            r_tick   <= n_tick;
        end
    end

endmodule

[rtl/rbop_objects.sv]
// Object position and motion registers: position strobes, move and motion writes
module rbop_objects
    import rbop_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_acc,
    input  t_obj_cmd i_cmd,
    output t_pos_arr o_pos
);

    t_pos_arr   r_pos, n_pos;
    t_mot_arr   r_mot, n_mot;
    t_pos_arr   hm_pos;
    logic [2:0] res_idx;
    logic [7:0] res_val;

    always_comb begin
        for (int i = 0; i < NUM_OBJ; i++) begin
            hm_pos[i] = mod_width(10'(r_pos[i]) + 10'(SCREEN_WIDTH) - 10'(signed'(r_mot[i])));
        end

        res_idx = i_cmd.mode[2:0] - 3'(MD_RESP0);
        if (i_cmd.column <= HBLANK_END) begin
            res_val = (i_cmd.mode == MD_RESP0 || i_cmd.mode == MD_RESP1) ?
                      PLAYER_RES_POS : OTHER_RES_POS;
        end else begin
            res_val = i_cmd.column - HBLANK_END;
        end

        n_pos = r_pos;
        n_mot = r_mot;
        unique case (t_mode'(i_cmd.mode))
            MD_RESP0, MD_RESP1, MD_RESM0, MD_RESM1, MD_RESBL: n_pos[res_idx] = res_val;
            MD_HMOVE: n_pos = hm_pos;
            MD_HMCLR: n_mot = '0;
            MD_SETMV: begin
                if (i_cmd.object_sel < 3'(NUM_OBJ)) n_mot[i_cmd.object_sel] = i_cmd.motion_value;
            end
            default: ;
        endcase
        o_pos = n_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_mot <= '0;
        end else if (i_acc) begin
            r_pos <= n_pos;
            r_mot <= n_mot;
        end
    end

endmodule

[rtl/rbop_out_buf.sv]
// Two-entry result buffer: output register plus skid entry
module rbop_out_buf
    import rbop_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_result     i_data,
    output logic        o_ready,
    rbop_out_if.source  o_out
);

    t_result r_head, r_skid;
    logic    r_head_vld, r_skid_vld;
    logic    pop;

    assign pop     = r_head_vld && o_out.ready;
    assign o_ready = !r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (pop) begin
            r_head_vld <= r_skid_vld || i_push;
            r_skid_vld <= r_skid_vld && i_push;
        end else if (i_push) begin
            r_head_vld <= 1'b1;
            r_skid_vld <= r_head_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_head <= r_skid_vld ? r_skid : i_data;
            if (r_skid_vld) r_skid <= i_data;
        end else if (i_push) begin
            if (r_head_vld) r_skid <= i_data;
            else            r_head <= i_data;
        end
    end

    assign o_out.valid        = r_head_vld;
    assign o_out.beam_column  = r_head.beam.beam_column;
    assign o_out.beam_line    = r_head.beam.beam_line;
    assign o_out.region       = r_head.beam.region;
    assign o_out.frame_done   = r_head.beam.frame_done;
    assign o_out.draw_line    = r_head.beam.draw_line;
    assign o_out.player0_pos  = r_head.pos[0];
    assign o_out.player1_pos  = r_head.pos[1];
    assign o_out.missile0_pos = r_head.pos[2];
    assign o_out.missile1_pos = r_head.pos[3];
    assign o_out.ball_pos     = r_head.pos[4];

endmodule

[rtl/raster_beam_and_object_position_core.sv]
// Top level of the raster beam and object position core
// Throughput: one input beat per cycle unless the output stalls; the whole tick update
// is one pass of logic between the state registers, and the result of each accepted
// beat is registered into a two-entry output buffer that absorbs one stalled beat.
// Reset (synchronous, active low): beam at column 0, line 0, vsync region, tick
// counter, positions and motion cleared, output buffer emptied.
module raster_beam_and_object_position_core
    import rbop_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    rbop_in_if.sink    i_in,
    rbop_out_if.source o_out
);

    logic       acc;
    logic       buf_ready;
    logic [7:0] col_pre;
    t_beam_cmd  beam_cmd;
    t_obj_cmd   obj_cmd;
    t_beam_res  beam_res;
    t_pos_arr   pos;
    t_result    res;

    assign i_in.ready = buf_ready;
    assign acc        = i_in.valid && buf_ready;

    assign beam_cmd.mode     = i_in.mode;
    assign beam_cmd.vsync_on = i_in.vsync_on;

    assign obj_cmd.mode         = i_in.mode;
    assign obj_cmd.object_sel   = i_in.object_sel;
    assign obj_cmd.motion_value = i_in.motion_value;
    assign obj_cmd.column       = col_pre;

    rbop_beam u_beam (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_cmd     (beam_cmd),
        .o_col_pre (col_pre),
        .o_res     (beam_res)
    );

    rbop_objects u_objects (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_cmd   (obj_cmd),
        .o_pos   (pos)
    );

    assign res.beam = beam_res;
    assign res.pos  = pos;

    rbop_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (acc),
        .i_data  (res),
        .o_ready (buf_ready),
        .o_out   (o_out)
    );

endmodule

[rtl/rbop_checker.sv]
// Port-level checks for the raster beam and object position core, with bind
module rbop_checker
    import rbop_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_beam_column,
    input logic [8:0] i_beam_line,
    input logic [7:0] i_player0_pos,
    input logic [7:0] i_ball_pos
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered straight after reset");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_beam_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_beam_column < LINE_TICKS) && (i_beam_line < LAST_LINE))
        else $error("beam outside raster");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_player0_pos < 8'(SCREEN_WIDTH)) && (i_ball_pos < 8'(SCREEN_WIDTH)))
        else $error("object position beyond screen width");

endmodule

bind raster_beam_and_object_position_core rbop_checker u_rbop_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_beam_column (o_out.beam_column),
    .i_beam_line   (o_out.beam_line),
    .i_player0_pos (o_out.player0_pos),
    .i_ball_pos    (o_out.ball_pos)
);

[verif/tb.sv]
// Testbench for the raster beam and object position core: predicted beam, region and positions
module tb;
    import rbop_pkg::*;

    localparam int          WATCHDOG_LIMIT   = 1000;
    localparam int          MAX_REPORTS      = 100;
    localparam logic [3:0]  FIRST_SPARE_MODE = 4'd10;
    localparam logic [3:0]  LAST_SPARE_MODE  = 4'd15;
    localparam logic [2:0]  SEL_P0           = 3'd0;
    localparam logic [2:0]  SEL_P1           = 3'd1;
    localparam logic [2:0]  SEL_M0           = 3'd2;
    localparam logic [2:0]  SEL_M1           = 3'd3;
    localparam logic [2:0]  SEL_BALL         = 3'd4;
    localparam logic [2:0]  SEL_SPARE_LO     = 3'd5;
    localparam logic [2:0]  SEL_SPARE_HI     = 3'd7;

    typedef struct packed {
        logic [7:0]      column;
        logic [8:0]      line;
        logic [2:0]      region;
        logic            frame_done;
        logic            draw;
        logic [4:0][7:0] pos;
    } t_beam_snapshot;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rbop_in_if  in_ch ();
    rbop_out_if out_ch ();

    raster_beam_and_object_position_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // raster state as the block should hold it
    logic [7:0]        ray_col;
    logic [8:0]        ray_line;
    logic [2:0]        ray_region;
    logic [14:0]       tick_total;
    logic [7:0]        obj_pos [5];
    logic signed [3:0] obj_motion [5];

    t_beam_snapshot pending_beams [$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_request   = 0;
    int hold_left      = 0;

    task automatic clear_raster;
        ray_col    = '0;
        ray_line   = '0;
        ray_region = RC_VSYNC;
        tick_total = '0;
        for (int i = 0; i < NUM_OBJ; i++) begin
            obj_pos[i]    = '0;
            obj_motion[i] = '0;
        end
    endtask

    task automatic advance_raster(input logic [3:0] md, input logic [2:0] sel,
                                  input logic [3:0] mv, input logic vs);
        t_beam_snapshot snap;
        logic           done;
        logic           drw;
        int             v;
        int             idx;
        done = 1'b0;
        drw  = 1'b0;
        tick_total = tick_total + 1'b1;
        if (tick_total >= FRAME_TICKS) begin
            done       = 1'b1;
            tick_total = '0;
        end
        if (vs && ray_region != RC_VSYNC) begin
            ray_col    = '0;
            ray_line   = '0;
            ray_region = RC_VSYNC;
        end
        case (md)
            MD_WSYNC: begin
                if (ray_line >= DRAW_FIRST_LINE && ray_line < OVERSCAN_LINE)
                    drw = 1'b1;
                ray_line = ray_line + 1'b1;
                ray_col  = '0;
                if (ray_line >= LAST_LINE) begin
                    ray_line   = '0;
                    ray_region = RC_VSYNC;
                end else if (ray_line >= OVERSCAN_LINE) begin
                    ray_region = RC_OVERSCAN;
                end else if (ray_line >= DRAW_FIRST_LINE) begin
                    ray_region = RC_HBLANK;
                end else if (ray_line >= VBLANK_LINE) begin
                    ray_region = RC_VBLANK;
                end else begin
                    ray_region = RC_VSYNC;
                end
            end
            MD_RESP0, MD_RESP1, MD_RESM0, MD_RESM1, MD_RESBL: begin
                idx = int'(md) - int'(MD_RESP0);
                if (ray_col <= HBLANK_END)
                    obj_pos[idx] = (idx < 2) ? PLAYER_RES_POS : OTHER_RES_POS;
                else
                    obj_pos[idx] = ray_col - HBLANK_END;
            end
            MD_HMOVE: begin
                for (int i = 0; i < NUM_OBJ; i++) begin
                    v = int'(obj_pos[i]) - int'(obj_motion[i]) + int'(SCREEN_WIDTH);
                    obj_pos[i] = 8'(v % int'(SCREEN_WIDTH));
                end
            end
            MD_HMCLR: begin
                for (int i = 0; i < NUM_OBJ; i++)
                    obj_motion[i] = '0;
            end
            MD_SETMV: begin
                if (sel < NUM_OBJ)
                    obj_motion[sel] = mv;
            end
            default: ;
        endcase
        ray_col = ray_col + 1'b1;
        case (ray_region)
            RC_VSYNC: begin
                if (ray_col >= LINE_TICKS) begin
                    ray_col  = '0;
                    ray_line = ray_line + 1'b1;
                    if (ray_line >= VBLANK_LINE)
                        ray_region = RC_VBLANK;
                end
            end
            RC_VBLANK: begin
                if (ray_col >= LINE_TICKS) begin
                    ray_col  = '0;
                    ray_line = ray_line + 1'b1;
                    if (ray_line >= DRAW_FIRST_LINE)
                        ray_region = RC_HBLANK;
                end
            end
            RC_HBLANK: begin
                if (ray_col >= HBLANK_END)
                    ray_region = RC_DRAW;
            end
            RC_DRAW: begin
                if (ray_col >= LINE_TICKS) begin
                    ray_col  = '0;
                    ray_line = ray_line + 1'b1;
                    ray_region = (ray_line >= OVERSCAN_LINE) ? RC_OVERSCAN : RC_HBLANK;
                end
                // no drawing on the wrap into overscan
                if (ray_region != RC_OVERSCAN)
                    drw = 1'b1;
            end
            default: begin
                if (ray_col >= LINE_TICKS) begin
                    ray_col  = '0;
                    ray_line = ray_line + 1'b1;
                    if (ray_line >= LAST_LINE) begin
                        ray_line   = '0;
                        ray_region = RC_VSYNC;
                        done       = 1'b1;
                    end
                end
            end
        endcase
        snap.column     = ray_col;
        snap.line       = ray_line;
        snap.region     = ray_region;
        snap.frame_done = done;
        snap.draw       = drw;
        for (int i = 0; i < NUM_OBJ; i++)
            snap.pos[i] = obj_pos[i];
        pending_beams.push_back(snap);
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [8:0] got, input logic [8:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    always @(posedge i_clk) begin : result_check
        t_beam_snapshot want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_beams.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = pending_beams.pop_front();
                check_field("beam_column", out_ch.beam_column, want.column);
                check_field("beam_line", out_ch.beam_line, want.line);
                check_field("region", out_ch.region, want.region);
                check_field("frame_done", out_ch.frame_done, want.frame_done);
                check_field("draw_line", out_ch.draw_line, want.draw);
                check_field("player0_pos", out_ch.player0_pos, want.pos[0]);
                check_field("player1_pos", out_ch.player1_pos, want.pos[1]);
                check_field("missile0_pos", out_ch.missile0_pos, want.pos[2]);
                check_field("missile1_pos", out_ch.missile1_pos, want.pos[3]);
                check_field("ball_pos", out_ch.ball_pos, want.pos[4]);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic drive_tick(input logic [3:0] md, input logic [2:0] sel,
                              input logic [3:0] mv, input logic vs);
        int gap;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 3) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= md;
        in_ch.object_sel   <= sel;
        in_ch.motion_value <= mv;
        in_ch.vsync_on     <= vs;
        do @(posedge i_clk); while (!in_ch.ready);
        advance_raster(md, sel, mv, vs);
    endtask

    task automatic random_beat;
        int         r;
        logic [3:0] md;
        logic [2:0] sel;
        logic [3:0] mv;
        logic       vs;
        r   = $urandom_range(0, 99);
        sel = 3'($urandom);
        mv  = 4'($urandom);
        vs  = ($urandom_range(0, 99) < 2);
        if (r < 30)
            md = MD_TICK;
        else if (r < 55)
            md = MD_WSYNC;
        else if (r < 70)
            md = 4'($urandom_range(MD_RESP0, MD_RESBL));
        else if (r < 78)
            md = MD_HMOVE;
        else if (r < 83)
            md = MD_HMCLR;
        else if (r < 95)
            md = MD_SETMV;
        else
            md = 4'($urandom_range(FIRST_SPARE_MODE, LAST_SPARE_MODE));
        drive_tick(md, sel, mv, vs);
    endtask

    task automatic settle_outputs;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_beams.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic wsync_to_line(input logic [8:0] target);
        while (ray_line != target)
            drive_tick(MD_WSYNC, 3'($urandom), 4'($urandom), 1'b0);
    endtask

    // plain ticks, with position strobes at the hblank edge and the line end
    task automatic tick_to_region(input logic [2:0] target);
        logic [3:0] md;
        while (ray_region != target) begin
            if (ray_col == HBLANK_END)
                md = MD_RESP0;
            else if (ray_col == HBLANK_END + 1)
                md = MD_RESM1;
            else if (ray_col == LINE_TICKS - 1)
                md = MD_RESBL;
            else
                md = MD_TICK;
            drive_tick(md, 3'($urandom), 4'($urandom), 1'b0);
        end
    endtask

    task automatic test_strobe_extremes;
        drive_tick(MD_TICK, SEL_P0, 4'h0, 1'b1);
        drive_tick(MD_RESP0, SEL_P0, 4'h0, 1'b0);
        drive_tick(MD_RESP1, SEL_P0, 4'h0, 1'b0);
        drive_tick(MD_RESM0, SEL_P0, 4'h0, 1'b0);
        drive_tick(MD_RESM1, SEL_P0, 4'h0, 1'b0);
        drive_tick(MD_RESBL, SEL_P0, 4'h0, 1'b0);
        drive_tick(MD_SETMV, SEL_P0, 4'h7, 1'b0);
        drive_tick(MD_SETMV, SEL_P1, 4'h8, 1'b0);
        drive_tick(MD_SETMV, SEL_M0, 4'hF, 1'b0);
        drive_tick(MD_SETMV, SEL_M1, 4'h1, 1'b0);
        drive_tick(MD_SETMV, SEL_BALL, 4'h8, 1'b0);
        drive_tick(MD_SETMV, SEL_SPARE_LO, 4'h7, 1'b0);
        drive_tick(MD_SETMV, SEL_SPARE_HI, 4'hF, 1'b0);
        drive_tick(MD_HMOVE, SEL_P0, 4'h0, 1'b0);
        drive_tick(MD_HMOVE, SEL_P0, 4'h0, 1'b0);
        drive_tick(MD_HMCLR, SEL_P0, 4'h0, 1'b0);
        drive_tick(MD_HMOVE, SEL_P0, 4'h0, 1'b0);
        drive_tick(FIRST_SPARE_MODE, SEL_SPARE_HI, 4'hF, 1'b0);
        drive_tick(LAST_SPARE_MODE, SEL_P0, 4'h0, 1'b1);
        drive_tick(MD_WSYNC, SEL_P0, 4'h0, 1'b0);
        drive_tick(MD_WSYNC, SEL_P0, 4'h0, 1'b0);
        drive_tick(MD_WSYNC, SEL_P0, 4'h0, 1'b0);
        drive_tick(MD_WSYNC, SEL_P0, 4'h0, 1'b1);
    endtask

    // first visible line: through hblank into draw and round to the next line
    task automatic test_raster_sweep;
        wsync_to_line(DRAW_FIRST_LINE);
        tick_to_region(RC_DRAW);
        tick_to_region(RC_HBLANK);
    endtask

    task automatic test_random_ticks(input int count);
        repeat (count) random_beat();
    endtask

    task automatic test_output_backpressure;
        int saved_pct;
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        hold_request  = 60;
        repeat (24) random_beat();
        send_idle_pct = saved_pct;
    endtask

    task automatic test_pause_until_drained;
        repeat (12) random_beat();
        settle_outputs();
        repeat (12) random_beat();
    endtask

    initial begin
        in_ch.valid        = 1'b0;
        in_ch.mode         = MD_TICK;
        in_ch.object_sel   = '0;
        in_ch.motion_value = '0;
        in_ch.vsync_on     = 1'b0;
        out_ch.ready       = 1'b0;
        clear_raster();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 17;
        recv_idle_pct = 64;
        test_strobe_extremes();
        test_raster_sweep();
        test_random_ticks(70);

        send_idle_pct = 64;
        recv_idle_pct = 17;
        test_random_ticks(70);
        test_output_backpressure();
        test_pause_until_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_ticks(70);

        settle_outputs();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
